/* rtl/smfc_pkg.sv */
// ----------------------------------------------------------------------------
// SPI master FIFO controller package
// Shared payload types, register indexes, bit positions and reset values.
// ----------------------------------------------------------------------------
package smfc_pkg;

   localparam int QueueDepth   = 32;
   localparam int QueueAw      = $clog2(QueueDepth);
   localparam int QueueCw      = QueueAw + 1;
   localparam int MaxFrameBits = 32;

   localparam logic [1:0] REQ_READ   = 2'd0;
   localparam logic [1:0] REQ_WRITE  = 2'd1;
   localparam logic [1:0] REQ_REPLY  = 2'd2;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   localparam logic [3:0] IX_CONTROL = 4'd0;
   localparam logic [3:0] IX_DFSIZE  = 4'd1;
   localparam logic [3:0] IX_STATUS  = 4'd2;
   localparam logic [3:0] IX_INTCLR  = 4'd3;
   localparam logic [3:0] IX_RX      = 4'd4;
   localparam logic [3:0] IX_TX      = 4'd5;
   localparam logic [3:0] IX_CLKGEN  = 4'd6;
   localparam logic [3:0] IX_SS      = 4'd7;
   localparam logic [3:0] IX_MIS     = 4'd8;
   localparam logic [3:0] IX_RIS     = 4'd9;

   localparam int ST_OVERFLOW     = 2;
   localparam int ST_RX_FULL      = 4;
   localparam int ST_RX_FULL_NEXT = 5;
   localparam int ST_RX_EMPTY     = 6;
   localparam int ST_TX_FULL      = 8;
   localparam int ST_TX_FULL_NEXT = 9;
   localparam int ST_TX_EMPTY     = 10;

   localparam int CT_ENABLE = 0;
   localparam int CT_SPS    = 26;
   localparam int CT_BIG    = 29;
   localparam int CT_RESET  = 31;

   localparam logic [31:0] CONTROL_RESET = 32'h8000_0102;
   localparam logic [31:0] DFSIZE_RESET  = 32'h0000_0004;
   localparam logic [31:0] CLKGEN_RESET  = 32'h0000_0007;
   localparam logic [13:0] STATUS_RESET  = 14'h2440;
   localparam logic [QueueCw-1:0] DEPTH_SMALL = QueueCw'(4);

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  reg_index;
      logic [31:0] write_data;
      logic [31:0] reply_word;
   } req_payload_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq_level;
      logic        select_level;
      logic        frame_valid;
      logic [31:0] frame_word;
   } rsp_payload_type;

   typedef struct packed {
      logic load;
      logic exec;
   } smfc_cmd_type;

endpackage

/* rtl/smfc_ctrl.sv */
// ----------------------------------------------------------------------------
// SPI master FIFO controller sequencer
// Handshake control: accepts a transfer, runs its execute state, holds result.
// ----------------------------------------------------------------------------
module smfc_ctrl
   import smfc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output smfc_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   // The result register is free at an accept edge, so execution never overwrites it.
   assign req_stall = (state_ff != ST_IDLE) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign cmd.load  = accept;
   assign cmd.exec  = (state_ff == ST_EXEC);

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/smfc_dp.sv */
// ----------------------------------------------------------------------------
// SPI master FIFO controller datapath
// Register file, transmit and receive queues, frame count and chip select.
// ----------------------------------------------------------------------------
module smfc_dp
   import smfc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  smfc_cmd_type    cmd,
   input  req_payload_type req_payload,
   output rsp_payload_type rsp_payload
);

   req_payload_type req_ff;
   rsp_payload_type rsp_ff, rsp_in;

   logic [31:0] tx_mem [QueueDepth];
   logic [31:0] rx_mem [QueueDepth];
   logic [31:0] tx_rd_ff, rx_rd_ff;

   logic [31:0] ctrl_ff, ctrl_in, dfsize_ff, dfsize_in, intclr_ff, intclr_in;
   logic [31:0] clkgen_ff, clkgen_in, ss_ff, ss_in;
   logic [13:0] status_ff, status_in;
   logic [2:0]  ris_ff, ris_in;
   logic [QueueAw-1:0] tx_head_ff, tx_head_in, rx_head_ff, rx_head_in;
   logic [QueueCw-1:0] tx_used_ff, tx_used_in, rx_used_ff, rx_used_in;
   logic [QueueCw-1:0] depth_ff, depth_in;
   logic [15:0] frames_ff, frames_in;
   logic        enabled_ff, enabled_in, pending_ff, pending_in, select_ff, select_in;

   logic               tx_we, rx_we, do_adv, sw_reset;
   logic [QueueAw-1:0] tx_wa, rx_wa;
   logic [31:0]        rdata, fword;
   logic               fvalid;
   logic [5:0]         fsize;
   logic [2:0]         irq_en;

   always_comb begin
      ctrl_in = ctrl_ff;     dfsize_in = dfsize_ff; intclr_in = intclr_ff;
      clkgen_in = clkgen_ff; ss_in = ss_ff;         status_in = status_ff;
      ris_in = ris_ff;       tx_head_in = tx_head_ff; rx_head_in = rx_head_ff;
      tx_used_in = tx_used_ff; rx_used_in = rx_used_ff; depth_in = depth_ff;
      frames_in = frames_ff; enabled_in = enabled_ff; pending_in = pending_ff;
      select_in = select_ff;
      tx_we = 1'b0; rx_we = 1'b0; do_adv = 1'b0; sw_reset = 1'b0;
      tx_wa = tx_head_ff + tx_used_ff[QueueAw-1:0];
      rx_wa = rx_head_ff + rx_used_ff[QueueAw-1:0];
      rdata = '0; fword = '0; fvalid = 1'b0;
      fsize = dfsize_ff[5:0];
      case (req_ff.req_type)
         REQ_READ: begin
            if (req_ff.reg_index == IX_RX) begin
               status_in[ST_RX_FULL]  = 1'b0;
               status_in[ST_OVERFLOW] = 1'b0;
               if (rx_used_ff != '0) begin
                  rdata      = rx_rd_ff;
                  rx_head_in = rx_head_ff + 1'b1;
                  rx_used_in = rx_used_ff - 1'b1;
               end
               if (rx_used_in == '0) status_in[ST_RX_EMPTY] = 1'b1;
            end else begin
               case (req_ff.reg_index)
                  IX_CONTROL: rdata = ctrl_ff;
                  IX_DFSIZE:  rdata = dfsize_ff;
                  IX_STATUS:  rdata = {18'd0, status_ff};
                  IX_INTCLR:  rdata = intclr_ff;
                  IX_CLKGEN:  rdata = clkgen_ff;
                  IX_SS:      rdata = ss_ff;
                  IX_MIS:     rdata = {29'd0, ris_ff & {ctrl_ff[6], ctrl_ff[4], ctrl_ff[5]}};
                  IX_RIS:     rdata = {29'd0, ris_ff};
                  default:    rdata = '0;
               endcase
            end
         end
         REQ_WRITE: begin
            case (req_ff.reg_index)
               IX_TX: begin
                  if (tx_used_ff < depth_ff) begin
                     status_in[ST_TX_EMPTY] = 1'b0;
                     tx_we      = 1'b1;
                     tx_used_in = tx_used_ff + 1'b1;
                     if (tx_used_in == depth_ff - 1'b1) status_in[ST_TX_FULL_NEXT] = 1'b1;
                     else if (tx_used_in == depth_ff) status_in[ST_TX_FULL] = 1'b1;
                     do_adv = enabled_ff;
                  end
               end
               IX_CONTROL: begin
                  ctrl_in = req_ff.write_data;
                  if (req_ff.write_data[CT_BIG]) begin
                     if (fsize <= 6'd8) depth_in = QueueCw'(32);
                     else if (fsize <= 6'd16) depth_in = QueueCw'(16);
                     else depth_in = QueueCw'(8);
                  end else begin
                     depth_in = DEPTH_SMALL;
                  end
                  if (depth_in > QueueCw'(QueueDepth)) depth_in = QueueCw'(QueueDepth);
                  enabled_in = req_ff.write_data[CT_ENABLE];
                  frames_in  = req_ff.write_data[23:8];
                  sw_reset   = req_ff.write_data[CT_RESET];
               end
               IX_DFSIZE: begin
                  if (!enabled_ff && req_ff.write_data[5:0] <= 6'(MaxFrameBits))
                     dfsize_in = req_ff.write_data;
               end
               IX_INTCLR: begin
                  intclr_in = req_ff.write_data;
                  ris_in    = ris_ff & ~req_ff.write_data[2:0];
               end
               IX_CLKGEN: clkgen_in = req_ff.write_data;
               IX_SS:     ss_in = req_ff.write_data;
               default: ;
            endcase
         end
         REQ_REPLY: begin
            if (pending_ff) begin
               pending_in = 1'b0;
               if (rx_used_ff >= depth_ff) begin
                  status_in[ST_OVERFLOW] = 1'b1;
                  ris_in[ST_OVERFLOW]    = 1'b1;
               end else begin
                  rx_we      = 1'b1;
                  rx_used_in = rx_used_ff + 1'b1;
                  status_in[ST_RX_EMPTY] = 1'b0;
                  if (rx_used_in == depth_ff - 1'b1) status_in[ST_RX_FULL_NEXT] = 1'b1;
                  else if (rx_used_in == depth_ff) status_in[ST_RX_FULL] = 1'b1;
               end
               if (frames_ff != '0) frames_in = frames_ff - 1'b1;
               if (!ctrl_ff[CT_SPS]) select_in = 1'b1;
               do_adv = 1'b1;
            end
         end
         default: ;
      endcase

      // Launch the next frame, or close the count once it is spent.
      if (do_adv && !pending_in) begin
         if (enabled_in && tx_used_in != '0 && frames_in != '0) begin
            select_in      = 1'b0;
            status_in[1:0] = 2'b00;
            fvalid         = 1'b1;
            // An empty queue that was just written launches the written word.
            fword = (req_ff.req_type == REQ_WRITE && tx_used_ff == '0) ?
                    req_ff.write_data : tx_rd_ff;
            tx_head_in = tx_head_ff + 1'b1;
            tx_used_in = tx_used_in - 1'b1;
            pending_in = 1'b1;
         end else if (frames_in == '0) begin
            frames_in      = ctrl_ff[23:8];
            select_in      = 1'b1;
            ris_in[1:0]    = 2'b11;
            status_in[1:0] = 2'b11;
         end
      end

      if (sw_reset) begin
         ctrl_in = CONTROL_RESET; dfsize_in = DFSIZE_RESET; intclr_in = '0;
         clkgen_in = CLKGEN_RESET; ss_in = '0; status_in = STATUS_RESET; ris_in = '0;
         tx_head_in = '0; rx_head_in = '0; tx_used_in = '0; rx_used_in = '0;
         depth_in = DEPTH_SMALL; frames_in = 16'd1; enabled_in = 1'b0;
         pending_in = 1'b0; select_in = 1'b1;
         rdata = '0; fvalid = 1'b0; fword = '0;
      end

      irq_en = {ctrl_in[6], ctrl_in[4], ctrl_in[5]};
      rsp_in.read_data    = rdata;
      rsp_in.irq_level    = |(irq_en & ris_in);
      rsp_in.select_level = select_in;
      rsp_in.frame_valid  = fvalid;
      rsp_in.frame_word   = fword;
   end

   always_ff @(posedge clock) begin
      tx_rd_ff <= tx_mem[tx_head_ff];
      rx_rd_ff <= rx_mem[rx_head_ff];
      if (cmd.exec && tx_we) tx_mem[tx_wa] <= req_ff.write_data;
      if (cmd.exec && rx_we) rx_mem[rx_wa] <= req_ff.reply_word;
      if (cmd.load) req_ff <= req_payload;
      if (cmd.exec) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= CONTROL_RESET; dfsize_ff <= DFSIZE_RESET; intclr_ff <= '0;
         clkgen_ff <= CLKGEN_RESET; ss_ff <= '0; status_ff <= STATUS_RESET; ris_ff <= '0;
         tx_head_ff <= '0; rx_head_ff <= '0; tx_used_ff <= '0; rx_used_ff <= '0;
         depth_ff <= DEPTH_SMALL; frames_ff <= 16'd1; enabled_ff <= 1'b0;
         pending_ff <= 1'b0; select_ff <= 1'b1;
      end else if (cmd.exec) begin
         ctrl_ff <= ctrl_in; dfsize_ff <= dfsize_in; intclr_ff <= intclr_in;
         clkgen_ff <= clkgen_in; ss_ff <= ss_in; status_ff <= status_in; ris_ff <= ris_in;
         tx_head_ff <= tx_head_in; rx_head_ff <= rx_head_in;
         tx_used_ff <= tx_used_in; rx_used_ff <= rx_used_in;
         depth_ff <= depth_in; frames_ff <= frames_in; enabled_ff <= enabled_in;
         pending_ff <= pending_in; select_ff <= select_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

/* rtl/spi_master_fifo_controller.sv */
// ----------------------------------------------------------------------------
// SPI master FIFO controller
// Bus register block with transmit and receive queues for an SPI master.
// ----------------------------------------------------------------------------
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req_payload (bus read, bus write, reply)
//   result  | rsp_valid | rsp_stall | rsp_payload (one per request)
//
// Each request is first captured, with both queue heads read, and then executed;
// no new request is taken while one is executing.
// The result register is loaded at the end of the execute state.
// Reset is synchronous; a soft reset through CONTROL bit 31 still returns a result.
// A result held under stall blocks the next request until it has been taken.
module spi_master_fifo_controller
   import smfc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output rsp_payload_type rsp_payload
);

   smfc_cmd_type cmd;

   smfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   smfc_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

`ifndef SYNTH
   a_load_exec : assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> cmd.exec) else $error("accepted transfer not executed");
   a_exec_rsp : assert property (@(posedge clock) disable iff (reset)
      cmd.exec |=> rsp_valid) else $error("executed transfer gave no result");
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> !rsp_valid) else $error("result register overwritten");
`endif

endmodule
